// ----- hw/rtl/i2cbm_pkg.sv -----
`default_nettype none

package i2cbm_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

    // reset values of the configuration registers
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd40;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // bus command codes carried by a tick, the last two act as none
    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_STOP,
        OP_WRITE,
        OP_READ,
        OP_WAIT_ACK,
        OP_RSVD6,
        OP_RSVD7
    } t_op;

    // configuration seen by the bit engine
    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_timeout;
    } t_cfg;

    // one result item of the bit engine
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/i2cbm_cfg.sv -----
`default_nettype none

module i2cbm_cfg
    import i2cbm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output t_cfg             o_cfg
);

    logic [15:0] r_half_period;
    logic [7:0]  r_ack_timeout;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.half_period_ticks = r_half_period;
    assign o_cfg.ack_timeout       = r_ack_timeout;

endmodule

`default_nettype wire

// ----- hw/rtl/i2cbm_engine.sv -----
`default_nettype none

module i2cbm_engine
    import i2cbm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [2:0] i_operation,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic       i_ack_after_read,
    input  wire logic       i_sda_in,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_STOP_A,
        PH_STOP_B,
        PH_WR_HIGH,
        PH_WR_LOW,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_WA_LOW,
        PH_WA_HIGH,
        PH_WA_POLL
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_index, n_bit_index;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_delay, n_delay;
    logic [7:0]  r_wait, n_wait;
    logic [7:0]  r_received, n_received;
    logic        r_fail, n_fail;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drive, n_drive;
    logic        r_ack_latched, n_ack_latched;
    logic        n_done;
    logic [15:0] w_reload;

    // a zero half period behaves as one tick
    assign w_reload = (i_cfg.half_period_ticks == 16'd0) ? 16'd1 : i_cfg.half_period_ticks;

    // one tick of the bit engine
    always_comb begin
        n_phase       = r_phase;
        n_bit_index   = r_bit_index;
        n_shift       = r_shift;
        n_delay       = r_delay;
        n_wait        = r_wait;
        n_received    = r_received;
        n_fail        = r_fail;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_drive       = r_drive;
        n_ack_latched = r_ack_latched;
        n_done        = 1'b0;

        if (r_phase == PH_IDLE) begin
            // command decode, only while idle
            case (i_operation)
                OP_START: begin
                    {n_scl, n_sda, n_drive} = 3'b111;
                    n_phase = PH_START_A;
                    n_delay = w_reload;
                end
                OP_STOP: begin
                    {n_scl, n_sda, n_drive} = 3'b001;
                    n_phase = PH_STOP_A;
                    n_delay = w_reload;
                end
                OP_WRITE: begin
                    n_shift     = i_tx_byte;
                    n_bit_index = 4'd0;
                    {n_scl, n_sda, n_drive} = {1'b1, i_tx_byte[7], 1'b1};
                    n_phase = PH_WR_HIGH;
                    n_delay = w_reload;
                end
                OP_READ: begin
                    n_shift       = 8'd0;
                    n_bit_index   = 4'd0;
                    n_ack_latched = i_ack_after_read;
                    {n_scl, n_drive} = 2'b00;
                    n_phase = PH_RD_LOW;
                    n_delay = w_reload;
                end
                OP_WAIT_ACK: begin
                    n_fail = 1'b0;
                    n_wait = 8'd0;
                    {n_scl, n_sda, n_drive} = 3'b010;
                    n_phase = PH_WA_LOW;
                    n_delay = w_reload;
                end
                default: ;
            endcase
        end else if (r_phase == PH_WA_POLL) begin
            // poll for the slave pulling sda low
            if (!i_sda_in) begin
                {n_scl, n_sda, n_drive} = 3'b010;
                n_phase = PH_IDLE;
                n_done  = 1'b1;
            end else if (r_wait >= i_cfg.ack_timeout) begin
                n_fail = 1'b1;
                {n_scl, n_sda, n_drive} = 3'b001;
                n_phase = PH_STOP_A;
                n_delay = w_reload;
            end else begin
                n_wait = r_wait + 8'd1;
            end
        end else if (r_delay > 16'd1) begin
            n_delay = r_delay - 16'd1;
        end else begin
            // half period elapsed, move to the next phase
            n_delay = 16'd0;
            case (r_phase)
                PH_START_A: begin
                    {n_scl, n_sda, n_drive} = 3'b101;
                    n_phase = PH_START_B;
                    n_delay = w_reload;
                end
                PH_START_B: begin
                    {n_scl, n_sda, n_drive} = 3'b001;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                PH_STOP_A: begin
                    {n_scl, n_sda, n_drive} = 3'b111;
                    n_phase = PH_STOP_B;
                    n_delay = w_reload;
                end
                PH_STOP_B: begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                PH_WR_HIGH: begin
                    {n_scl, n_drive} = 2'b01;
                    n_phase = PH_WR_LOW;
                    n_delay = w_reload;
                end
                PH_WR_LOW: begin
                    n_bit_index = r_bit_index + 4'd1;
                    n_shift     = {r_shift[6:0], 1'b0};
                    if (n_bit_index >= 4'd8) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        {n_scl, n_sda, n_drive} = {1'b1, r_shift[6], 1'b1};
                        n_phase = PH_WR_HIGH;
                        n_delay = w_reload;
                    end
                end
                PH_RD_LOW: begin
                    n_shift = {r_shift[6:0], i_sda_in};
                    {n_scl, n_drive} = 2'b10;
                    n_phase = PH_RD_HIGH;
                    n_delay = w_reload;
                end
                PH_RD_HIGH: begin
                    n_bit_index = r_bit_index + 4'd1;
                    if (n_bit_index >= 4'd8) begin
                        n_received = r_shift;
                        {n_scl, n_sda, n_drive} = {1'b0, ~r_ack_latched, 1'b1};
                        n_phase = PH_ACK_LOW;
                    end else begin
                        {n_scl, n_drive} = 2'b00;
                        n_phase = PH_RD_LOW;
                    end
                    n_delay = w_reload;
                end
                PH_ACK_LOW: begin
                    {n_scl, n_drive} = 2'b11;
                    n_phase = PH_ACK_HIGH;
                    n_delay = w_reload;
                end
                PH_ACK_HIGH: begin
                    {n_scl, n_drive} = 2'b01;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                PH_WA_LOW: begin
                    {n_scl, n_sda, n_drive} = 3'b110;
                    n_phase = PH_WA_HIGH;
                    n_delay = w_reload;
                end
                PH_WA_HIGH: begin
                    n_phase = PH_WA_POLL;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // state registers, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_index   <= 4'd0;
            r_shift       <= 8'd0;
            r_delay       <= 16'd0;
            r_wait        <= 8'd0;
            r_received    <= 8'd0;
            r_fail        <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_drive       <= 1'b1;
            r_ack_latched <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bit_index   <= n_bit_index;
            r_shift       <= n_shift;
            r_delay       <= n_delay;
            r_wait        <= n_wait;
            r_received    <= n_received;
            r_fail        <= n_fail;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
            r_drive       <= n_drive;
            r_ack_latched <= n_ack_latched;
        end
    end

    // result of this tick, taken by the output register
    assign o_result.scl_out    = n_scl;
    assign o_result.sda_out    = n_sda;
    assign o_result.sda_drive  = n_drive;
    assign o_result.busy_res   = (n_phase != PH_IDLE);
    assign o_result.done_res   = n_done;
    assign o_result.rx_byte    = n_received;
    assign o_result.ack_failed = n_fail;

`ifndef SYNTHESIS
    // timed phases always hold a live delay count
    a_delay_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE && r_phase != PH_WA_POLL) |-> (r_delay != 16'd0))
        else $error("timed phase with zero delay count");

    // bit counter never runs past one byte
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= 4'd8)
        else $error("bit index beyond one byte");

    // state only moves on a tick
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_delay) && $stable(r_shift)))
        else $error("engine state changed without a tick");

    // slave acknowledge ends the poll
    a_ack_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_WA_POLL && !i_sda_in) |=> (r_phase == PH_IDLE))
        else $error("acknowledge not taken");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/i2c_bit_master_top.sv -----
// path: a transferred tick is held in the input register, and its result is registered in the
//   output register once that register is free
// throughput: one tick per cycle while i_stall does not hold back the output register
// reset: synchronous active-low i_rst_n; bus idle with scl/sda high and driven,
//   half period 40, ack timeout 250
`default_nettype none

module i2c_bit_master_top
    import i2cbm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_tx_byte,
    input  wire logic        i_ack_after_read,
    input  wire logic        i_sda_in,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_scl_out,
    output logic             o_sda_out,
    output logic             o_sda_drive,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [7:0]       o_rx_byte,
    output logic             o_ack_failed,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic       r_in_valid;
    logic [2:0] r_in_operation;
    logic [7:0] r_in_tx_byte;
    logic       r_in_ack_after_read;
    logic       r_in_sda_in;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    t_cfg       w_cfg;
    logic       w_out_free;
    logic       w_step;
    logic       w_in_take;

    assign o_cfg_ready = 1'b1;

    // handshake: evaluate when the output register can take the result
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_in_take  = i_valid && !o_stall;

    i2cbm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    i2cbm_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_operation      (r_in_operation),
        .i_tx_byte        (r_in_tx_byte),
        .i_ack_after_read (r_in_ack_after_read),
        .i_sda_in         (r_in_sda_in),
        .i_cfg            (w_cfg),
        .o_result         (w_result)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_operation      <= i_operation;
            r_in_tx_byte        <= i_tx_byte;
            r_in_ack_after_read <= i_ack_after_read;
            r_in_sda_in         <= i_sda_in;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_scl_out    = r_out.scl_out;
    assign o_sda_out    = r_out.sda_out;
    assign o_sda_drive  = r_out.sda_drive;
    assign o_busy_res   = r_out.busy_res;
    assign o_done_res   = r_out.done_res;
    assign o_rx_byte    = r_out.rx_byte;
    assign o_ack_failed = r_out.ack_failed;

endmodule

`default_nettype wire
